### rtl/pecd_pkg.sv
// shared types and constants for the pointer event click detector
package pecd_pkg;

  // event kinds carried in the slave tuser
  localparam logic [1:0] KIND_MOTION  = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // button codes with a fixed meaning
  localparam logic [2:0] CODE_WHEEL_UP   = 3'd5;
  localparam logic [2:0] CODE_WHEEL_DOWN = 3'd6;

  // wheel direction values
  localparam logic signed [1:0] WHEEL_NONE = 2'sd0;
  localparam logic signed [1:0] WHEEL_UP   = 2'sd1;
  localparam logic signed [1:0] WHEEL_DOWN = -2'sd1;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_X          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_Y          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DCLICK_WINDOW  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_MOVEMENT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_TIMEOUT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINTER_EN     = 3'd5;

  // configuration field widths
  localparam int MAX_COORD_W = 12;
  localparam int WINDOW_W    = 16;
  localparam int MIN_MOVE_W  = 12;
  localparam int MIN_SQ_W    = 2 * MIN_MOVE_W;
  localparam int TIMEOUT_W   = 20;
  localparam int TIME_W      = 32;

  // reset values of the configuration registers
  localparam logic [MAX_COORD_W-1:0] MAX_X_RESET   = 12'd720;
  localparam logic [MAX_COORD_W-1:0] MAX_Y_RESET   = 12'd576;
  localparam logic [WINDOW_W-1:0]    WINDOW_RESET  = 16'd500;
  localparam logic [MIN_SQ_W-1:0]    MIN_SQ_RESET  = 24'd25;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET = 20'd5000;

  // per-event status handed from the tracking stage to the activity stage
  typedef struct packed {
    logic wheel_nz;
    logic any_down;
    logic nothing_down;
  } evt_flags_t;

endpackage

### rtl/pecd_track.sv
// input register, position, wheel and button tracking with click masks
module pecd_track
  import pecd_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int NUM_BUTTONS = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  // incoming event beat
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [TIME_W-1:0]             in_time,
  input  logic [COORD_BITS-1:0]         in_x,
  input  logic [COORD_BITS-1:0]         in_y,
  input  logic [1:0]                    in_kind,
  input  logic [2:0]                    in_code,
  // configuration
  input  logic [MAX_COORD_W-1:0]        max_x,
  input  logic [MAX_COORD_W-1:0]        max_y,
  input  logic [WINDOW_W-1:0]           dclick_window,
  input  logic                          pos_invalidate,
  // tracked event toward the activity stage
  output logic                          mid_valid,
  input  logic                          mid_ready,
  output logic [TIME_W-1:0]             mid_time,
  output logic [COORD_BITS-1:0]         mid_cur_x,
  output logic [COORD_BITS-1:0]         mid_cur_y,
  output logic signed [COORD_BITS:0]    mid_delta_x,
  output logic signed [COORD_BITS:0]    mid_delta_y,
  output logic signed [1:0]             mid_wheel,
  output logic [NUM_BUTTONS-1:0]        mid_buttons,
  output logic [NUM_BUTTONS-1:0]        mid_clicks,
  output logic [NUM_BUTTONS-1:0]        mid_doubles,
  output logic [NUM_BUTTONS-1:0]        mid_holds,
  output logic [2*COORD_BITS-1:0]       mid_sq_x,
  output logic [2*COORD_BITS-1:0]       mid_sq_y,
  output evt_flags_t                    mid_flags
);

  localparam int CLAMP_W = (COORD_BITS > MAX_COORD_W) ? COORD_BITS : MAX_COORD_W;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam logic [3:0] BTN_LIMIT = 4'(NUM_BUTTONS);

  // input register
  logic                    iv;
  logic [TIME_W-1:0]       i_time;
  logic [COORD_BITS-1:0]   i_x;
  logic [COORD_BITS-1:0]   i_y;
  logic [1:0]              i_kind;
  logic [2:0]              i_code;

  // tracked state
  logic [COORD_BITS-1:0]   position_x;
  logic [COORD_BITS-1:0]   position_y;
  logic                    position_valid;
  logic signed [COORD_BITS:0] last_delta_x;
  logic signed [COORD_BITS:0] last_delta_y;
  logic signed [1:0]       wheel_state;
  logic [NUM_BUTTONS-1:0]  button_levels;
  logic [NUM_BUTTONS-1:0]  previous_levels;
  logic [TIME_W-1:0]       click_stamp [NUM_BUTTONS];

  // next values
  logic [COORD_BITS-1:0]   position_x_next;
  logic [COORD_BITS-1:0]   position_y_next;
  logic signed [COORD_BITS:0] delta_x_next;
  logic signed [COORD_BITS:0] delta_y_next;
  logic signed [1:0]       wheel_next;
  logic [NUM_BUTTONS-1:0]  levels_next;
  logic [NUM_BUTTONS-1:0]  clicks;
  logic [NUM_BUTTONS-1:0]  doubles;
  logic [NUM_BUTTONS-1:0]  holds;
  logic [TIME_W-1:0]       stamp_next [NUM_BUTTONS];
  logic [COORD_BITS-1:0]   mag_x;
  logic [COORD_BITS-1:0]   mag_y;
  logic [CLAMP_W-1:0]      wide_x;
  logic [CLAMP_W-1:0]      wide_y;
  logic [CLAMP_W-1:0]      lim_x;
  logic [CLAMP_W-1:0]      lim_y;
  logic                    is_press;
  logic                    is_button_evt;
  logic                    btn_hit;
  logic                    fire;

  // stage advance
  assign fire     = iv && (!mid_valid || mid_ready);
  assign in_ready = !iv || fire;

  // position clamp and delta
  always_comb begin
    wide_x = CLAMP_W'(i_x);
    wide_y = CLAMP_W'(i_y);
    lim_x  = CLAMP_W'(max_x);
    lim_y  = CLAMP_W'(max_y);
    position_x_next = (wide_x > lim_x) ? lim_x[COORD_BITS-1:0] : i_x;
    position_y_next = (wide_y > lim_y) ? lim_y[COORD_BITS-1:0] : i_y;
    if (position_valid) begin
      delta_x_next = $signed({1'b0, i_x}) - $signed({1'b0, position_x});
      delta_y_next = $signed({1'b0, i_y}) - $signed({1'b0, position_y});
    end else begin
      delta_x_next = last_delta_x;
      delta_y_next = last_delta_y;
    end
    mag_x = delta_x_next[COORD_BITS] ? COORD_BITS'(-delta_x_next) :
                                       delta_x_next[COORD_BITS-1:0];
    mag_y = delta_y_next[COORD_BITS] ? COORD_BITS'(-delta_y_next) :
                                       delta_y_next[COORD_BITS-1:0];
  end

  // wheel and button levels
  always_comb begin
    is_press      = (i_kind == KIND_PRESS);
    is_button_evt = (i_kind == KIND_PRESS) || (i_kind == KIND_RELEASE);
    btn_hit       = is_button_evt && (i_code != CODE_WHEEL_UP) &&
                    (i_code != CODE_WHEEL_DOWN) && ({1'b0, i_code} < BTN_LIMIT);
    wheel_next = wheel_state;
    if (is_button_evt && i_code == CODE_WHEEL_UP) begin
      wheel_next = is_press ? WHEEL_UP : WHEEL_NONE;
    end else if (is_button_evt && i_code == CODE_WHEEL_DOWN) begin
      wheel_next = is_press ? WHEEL_DOWN : WHEEL_NONE;
    end
    levels_next = button_levels;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (btn_hit && i_code == 3'(i)) begin
        levels_next[i] = is_press;
      end
    end
  end

  // per-button click, double-click and hold
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      holds[i]      = levels_next[i] && previous_levels[i];
      doubles[i]    = levels_next[i] && !previous_levels[i] &&
                      ((i_time - click_stamp[i]) < TIME_W'(dclick_window));
      clicks[i]     = !levels_next[i] && previous_levels[i];
      stamp_next[i] = clicks[i] ? i_time : click_stamp[i];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      i_time <= in_time;
      i_x    <= in_x;
      i_y    <= in_y;
      i_kind <= in_kind;
      i_code <= in_code;
    end
  end

  // tracked state update
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x      <= '0;
      position_y      <= '0;
      position_valid  <= 1'b0;
      last_delta_x    <= '0;
      last_delta_y    <= '0;
      wheel_state     <= WHEEL_NONE;
      button_levels   <= '0;
      previous_levels <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        click_stamp[i] <= '0;
      end
    end else if (fire) begin
      position_x      <= position_x_next;
      position_y      <= position_y_next;
      position_valid  <= 1'b1;
      last_delta_x    <= delta_x_next;
      last_delta_y    <= delta_y_next;
      wheel_state     <= wheel_next;
      button_levels   <= levels_next;
      previous_levels <= levels_next;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        click_stamp[i] <= stamp_next[i];
      end
    end else if (pos_invalidate) begin
      position_valid <= 1'b0;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (fire) begin
      mid_valid <= 1'b1;
    end else if (mid_ready) begin
      mid_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      mid_time    <= i_time;
      mid_cur_x   <= position_x_next;
      mid_cur_y   <= position_y_next;
      mid_delta_x <= delta_x_next;
      mid_delta_y <= delta_y_next;
      mid_wheel   <= wheel_next;
      mid_buttons <= levels_next;
      mid_clicks  <= clicks;
      mid_doubles <= doubles;
      mid_holds   <= holds;
      mid_sq_x    <= SQ_W'(mag_x) * SQ_W'(mag_x);
      mid_sq_y    <= SQ_W'(mag_y) * SQ_W'(mag_y);
      mid_flags.wheel_nz     <= (wheel_next != WHEEL_NONE);
      mid_flags.any_down     <= |levels_next;
      mid_flags.nothing_down <= ~|(levels_next | previous_levels);
    end
  end

endmodule

### rtl/pecd_activity.sv
// movement threshold, activity flag with timeout and result register
module pecd_activity
  import pecd_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int NUM_BUTTONS = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic [MIN_SQ_W-1:0]           min_move_sq,
  input  logic [TIMEOUT_W-1:0]          active_timeout,
  input  logic                          pointer_enabled,
  // tracked event
  input  logic                          mid_valid,
  output logic                          mid_ready,
  input  logic [TIME_W-1:0]             mid_time,
  input  logic [COORD_BITS-1:0]         mid_cur_x,
  input  logic [COORD_BITS-1:0]         mid_cur_y,
  input  logic signed [COORD_BITS:0]    mid_delta_x,
  input  logic signed [COORD_BITS:0]    mid_delta_y,
  input  logic signed [1:0]             mid_wheel,
  input  logic [NUM_BUTTONS-1:0]        mid_buttons,
  input  logic [NUM_BUTTONS-1:0]        mid_clicks,
  input  logic [NUM_BUTTONS-1:0]        mid_doubles,
  input  logic [NUM_BUTTONS-1:0]        mid_holds,
  input  logic [2*COORD_BITS-1:0]       mid_sq_x,
  input  logic [2*COORD_BITS-1:0]       mid_sq_y,
  input  evt_flags_t                    mid_flags,
  // result register
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_BITS-1:0]         cur_x,
  output logic [COORD_BITS-1:0]         cur_y,
  output logic signed [COORD_BITS:0]    delta_x,
  output logic signed [COORD_BITS:0]    delta_y,
  output logic signed [1:0]             wheel_dir,
  output logic [NUM_BUTTONS-1:0]        buttons_down,
  output logic [NUM_BUTTONS-1:0]        click_mask,
  output logic [NUM_BUTTONS-1:0]        double_click_mask,
  output logic [NUM_BUTTONS-1:0]        hold_mask,
  output logic                          moved,
  output logic                          active_out,
  output logic                          nothing_down
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = (SQ_W + 1 > TIME_W) ? TIME_W : SQ_W + 1;
  localparam int CMP_W = (SUM_W > MIN_SQ_W) ? SUM_W : MIN_SQ_W;

  logic                active_flag;
  logic [TIME_W-1:0]   active_stamp;
  logic                active_flag_next;
  logic [TIME_W-1:0]   active_stamp_next;
  logic [SQ_W:0]       sum_full;
  logic [SUM_W-1:0]    sum;
  logic                moved_now;
  logic                activate;
  logic                timed_out;
  logic                take;

  assign mid_ready = !out_valid || out_ready;
  assign take      = mid_valid && mid_ready;

  // squared distance against squared threshold, sum kept to at most 32 bits
  always_comb begin
    sum_full  = {1'b0, mid_sq_x} + {1'b0, mid_sq_y};
    sum       = sum_full[SUM_W-1:0];
    moved_now = CMP_W'(sum) >= CMP_W'(min_move_sq);
  end

  // activity set, then timeout check on wrapped elapsed time
  always_comb begin
    activate  = moved_now || mid_flags.wheel_nz || mid_flags.any_down;
    timed_out = active_flag &&
                ((mid_time - active_stamp) > TIME_W'(active_timeout));
    active_flag_next  = active_flag;
    active_stamp_next = active_stamp;
    if (activate) begin
      active_flag_next  = 1'b1;
      active_stamp_next = mid_time;
    end else if (timed_out) begin
      active_flag_next  = 1'b0;
      active_stamp_next = mid_time;
    end
  end

  // activity state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag  <= 1'b0;
      active_stamp <= '0;
    end else if (take) begin
      active_flag  <= active_flag_next;
      active_stamp <= active_stamp_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      cur_x             <= mid_cur_x;
      cur_y             <= mid_cur_y;
      delta_x           <= mid_delta_x;
      delta_y           <= mid_delta_y;
      wheel_dir         <= mid_wheel;
      buttons_down      <= mid_buttons;
      click_mask        <= mid_clicks;
      double_click_mask <= mid_doubles;
      hold_mask         <= mid_holds;
      moved             <= moved_now;
      active_out        <= active_flag_next && pointer_enabled;
      nothing_down      <= mid_flags.nothing_down;
    end
  end

endmodule

### rtl/pointer_event_click_detector.sv
// top level of the pointer event click detector with configuration registers
//
// Usage: each slave beat is one time-stamped pointer event (time, absolute
// position, kind and button code); each master beat is the result for that
// event: clamped position, last delta, wheel, held buttons, click,
// double-click and hold masks, moved flag, activity flag, nothing-down flag.
// Registers are to be written through the cfg channel (cfg_ready is always
// high) only while no event is in flight; the block does not enforce this.
// A max_x or max_y write gives the next event its position without a delta.
// Each slave beat passes in order through the input register, the tracking
// stage register and the activity stage result register that drives m_tvalid.
// Throughput: one event per cycle unless the receiver stalls; the activity
// flag and button state each update in a single stage, so events need no gap.
// Reset clears all pointer, button and activity state and loads the
// register defaults; the pipeline comes up empty.
// When the receiver stalls, the result register holds its beat and the
// stages in front keep filling; s_tready drops once all three are full.
module pointer_event_click_detector
  import pecd_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int NUM_BUTTONS = 5,
  localparam int IN_W        = TIME_W + 2 * COORD_BITS,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = 4 * COORD_BITS + 4 * NUM_BUTTONS + 7,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8,
  localparam int OUT_PAD     = OUT_TDATA_W - OUT_W
) (
  input  logic                         clk,
  input  logic                         rst,
  // event stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // event_time, pos_x, pos_y
  input  logic [IN_TDATA_W-1:0]        s_tdata,
  // event_kind, button_code
  input  logic [4:0]                   s_tuser,
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // cur_x, cur_y, delta_x, delta_y, wheel_dir, buttons_down, click_mask,
  // double_click_mask, hold_mask, moved, active_out, nothing_down, zero fill
  output logic [OUT_TDATA_W-1:0]       m_tdata,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // configuration registers
  logic [MAX_COORD_W-1:0] max_x;
  logic [MAX_COORD_W-1:0] max_y;
  logic [WINDOW_W-1:0]    dclick_window;
  logic [MIN_SQ_W-1:0]    min_move_sq;
  logic [TIMEOUT_W-1:0]   active_timeout;
  logic                   pointer_enabled;
  logic                   cfg_write;
  logic                   pos_invalidate;
  logic [MIN_MOVE_W-1:0]  min_move_in;

  // stage link
  logic                          mid_valid;
  logic                          mid_ready;
  logic [TIME_W-1:0]             mid_time;
  logic [COORD_BITS-1:0]         mid_cur_x;
  logic [COORD_BITS-1:0]         mid_cur_y;
  logic signed [COORD_BITS:0]    mid_delta_x;
  logic signed [COORD_BITS:0]    mid_delta_y;
  logic signed [1:0]             mid_wheel;
  logic [NUM_BUTTONS-1:0]        mid_buttons;
  logic [NUM_BUTTONS-1:0]        mid_clicks;
  logic [NUM_BUTTONS-1:0]        mid_doubles;
  logic [NUM_BUTTONS-1:0]        mid_holds;
  logic [2*COORD_BITS-1:0]       mid_sq_x;
  logic [2*COORD_BITS-1:0]       mid_sq_y;
  evt_flags_t                    mid_flags;

  // result fields
  logic [COORD_BITS-1:0]         cur_x;
  logic [COORD_BITS-1:0]         cur_y;
  logic signed [COORD_BITS:0]    delta_x;
  logic signed [COORD_BITS:0]    delta_y;
  logic signed [1:0]             wheel_dir;
  logic [NUM_BUTTONS-1:0]        buttons_down;
  logic [NUM_BUTTONS-1:0]        click_mask;
  logic [NUM_BUTTONS-1:0]        double_click_mask;
  logic [NUM_BUTTONS-1:0]        hold_mask;
  logic                          moved;
  logic                          active_out;
  logic                          nothing_down;

  // configuration write decode
  assign cfg_ready      = 1'b1;
  assign cfg_write      = cfg_valid && cfg_ready;
  assign pos_invalidate = cfg_write &&
                          (cfg_index == CFG_MAX_X || cfg_index == CFG_MAX_Y);
  assign min_move_in    = cfg_data[MIN_MOVE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x           <= MAX_X_RESET;
      max_y           <= MAX_Y_RESET;
      dclick_window   <= WINDOW_RESET;
      min_move_sq     <= MIN_SQ_RESET;
      active_timeout  <= TIMEOUT_RESET;
      pointer_enabled <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_X:          max_x           <= cfg_data[MAX_COORD_W-1:0];
        CFG_MAX_Y:          max_y           <= cfg_data[MAX_COORD_W-1:0];
        CFG_DCLICK_WINDOW:  dclick_window   <= cfg_data[WINDOW_W-1:0];
        CFG_MIN_MOVEMENT:   min_move_sq     <= MIN_SQ_W'(min_move_in) *
                                               MIN_SQ_W'(min_move_in);
        CFG_ACTIVE_TIMEOUT: active_timeout  <= cfg_data[TIMEOUT_W-1:0];
        CFG_POINTER_EN:     pointer_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // tracking stage
  pecd_track #(
    .COORD_BITS  (COORD_BITS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_time        (s_tdata[TIME_W-1:0]),
    .in_x           (s_tdata[TIME_W +: COORD_BITS]),
    .in_y           (s_tdata[TIME_W + COORD_BITS +: COORD_BITS]),
    .in_kind        (s_tuser[1:0]),
    .in_code        (s_tuser[4:2]),
    .max_x          (max_x),
    .max_y          (max_y),
    .dclick_window  (dclick_window),
    .pos_invalidate (pos_invalidate),
    .mid_valid      (mid_valid),
    .mid_ready      (mid_ready),
    .mid_time       (mid_time),
    .mid_cur_x      (mid_cur_x),
    .mid_cur_y      (mid_cur_y),
    .mid_delta_x    (mid_delta_x),
    .mid_delta_y    (mid_delta_y),
    .mid_wheel      (mid_wheel),
    .mid_buttons    (mid_buttons),
    .mid_clicks     (mid_clicks),
    .mid_doubles    (mid_doubles),
    .mid_holds      (mid_holds),
    .mid_sq_x       (mid_sq_x),
    .mid_sq_y       (mid_sq_y),
    .mid_flags      (mid_flags)
  );

  // activity stage and result register
  pecd_activity #(
    .COORD_BITS  (COORD_BITS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_activity (
    .clk               (clk),
    .rst               (rst),
    .min_move_sq       (min_move_sq),
    .active_timeout    (active_timeout),
    .pointer_enabled   (pointer_enabled),
    .mid_valid         (mid_valid),
    .mid_ready         (mid_ready),
    .mid_time          (mid_time),
    .mid_cur_x         (mid_cur_x),
    .mid_cur_y         (mid_cur_y),
    .mid_delta_x       (mid_delta_x),
    .mid_delta_y       (mid_delta_y),
    .mid_wheel         (mid_wheel),
    .mid_buttons       (mid_buttons),
    .mid_clicks        (mid_clicks),
    .mid_doubles       (mid_doubles),
    .mid_holds         (mid_holds),
    .mid_sq_x          (mid_sq_x),
    .mid_sq_y          (mid_sq_y),
    .mid_flags         (mid_flags),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .cur_x             (cur_x),
    .cur_y             (cur_y),
    .delta_x           (delta_x),
    .delta_y           (delta_y),
    .wheel_dir         (wheel_dir),
    .buttons_down      (buttons_down),
    .click_mask        (click_mask),
    .double_click_mask (double_click_mask),
    .hold_mask         (hold_mask),
    .moved             (moved),
    .active_out        (active_out),
    .nothing_down      (nothing_down)
  );

  // result beat packing, first field in the low bits
  assign m_tdata = {{OUT_PAD{1'b0}}, nothing_down, active_out, moved, hold_mask,
                    double_click_mask, click_mask, buttons_down, wheel_dir,
                    delta_y, delta_x, cur_y, cur_x};

endmodule

### tb/tb_pointer_event_click_detector.sv
// self-checking testbench for the pointer event click detector
`timescale 1ns / 100ps

module tb_pointer_event_click_detector;
  import pecd_pkg::*;

  localparam int IN_W           = 56;
  localparam int OUT_W          = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int END_PAUSE      = 20;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASES         = 8;
  localparam int PHASE_EVENTS   = 100;

  // event kind and button codes without a name in the package
  localparam logic [1:0] KIND_OTHER  = 2'd3;
  localparam logic [2:0] CODE_LEFT   = 3'd0;
  localparam logic [2:0] CODE_RIGHT  = 3'd1;
  localparam logic [2:0] CODE_EXTRA2 = 3'd4;
  localparam logic [2:0] CODE_NONE   = 3'd7;

  // result beat, first member in the highest bits
  typedef struct packed {
    logic [4:0]         fill;
    logic               nothing_down;
    logic               active_out;
    logic               moved;
    logic [4:0]         hold_mask;
    logic [4:0]         dclick_mask;
    logic [4:0]         click_mask;
    logic [4:0]         buttons_down;
    logic signed [1:0]  wheel_dir;
    logic signed [12:0] delta_y;
    logic signed [12:0] delta_x;
    logic [11:0]        cur_y;
    logic [11:0]        cur_x;
  } click_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata;
  logic [4:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_W-1:0]       m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // mirrored configuration
  logic [11:0] lim_x, lim_y, min_move;
  logic [15:0] dclick_window;
  logic [19:0] idle_timeout;
  logic        ptr_enable;

  // mirrored pointer state
  logic [11:0]        trk_x, trk_y;
  logic               trk_valid;
  logic signed [12:0] step_x, step_y;
  logic signed [1:0]  wheel_q;
  logic [4:0]         btn_now, btn_prev;
  logic [31:0]        release_stamp [5];
  logic               act_q;
  logic [31:0]        act_stamp;

  click_result_t expected_results [$];
  int          mismatch_count;
  int          events_sent, results_seen, cfg_writes;
  int          clicks_seen, dclicks_seen, holds_seen, timeouts_seen;
  int          idle_cycles;
  logic        no_idle;
  logic [31:0] clock_now;
  int          walk_x, walk_y;

  pointer_event_click_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register write as seen by the block
  task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_MAX_X: begin
        lim_x     = value[11:0];
        trk_valid = 1'b0;
      end
      CFG_MAX_Y: begin
        lim_y     = value[11:0];
        trk_valid = 1'b0;
      end
      CFG_DCLICK_WINDOW:  dclick_window = value[15:0];
      CFG_MIN_MOVEMENT:   min_move      = value[11:0];
      CFG_ACTIVE_TIMEOUT: idle_timeout  = value[19:0];
      CFG_POINTER_EN:     ptr_enable    = value[0];
      default: ;
    endcase
  endtask

  // one event through the tracker, updates the mirrored state
  task automatic predict_pointer(input logic [31:0] now, input logic [11:0] px,
                                 input logic [11:0] py, input logic [1:0] kind,
                                 input logic [2:0] code, output click_result_t r);
    int          ax, ay;
    longint      dist_sq, floor_sq;
    logic        moved, nothing, press;
    logic [4:0]  clicks, dclicks, holds;
    logic [31:0] elapsed;
    clicks  = '0;
    dclicks = '0;
    holds   = '0;
    nothing = 1'b1;

    // position and delta; an invalid position takes no delta
    if (trk_valid) begin
      step_x = 13'(int'(px) - int'(trk_x));
      step_y = 13'(int'(py) - int'(trk_y));
    end
    trk_x     = (px > lim_x) ? lim_x : px;
    trk_y     = (py > lim_y) ? lim_y : py;
    trk_valid = 1'b1;

    // buttons and wheel; kind three is motion only
    if (kind == KIND_PRESS || kind == KIND_RELEASE) begin
      press = (kind == KIND_PRESS);
      if (code == CODE_WHEEL_UP)
        wheel_q = press ? WHEEL_UP : WHEEL_NONE;
      else if (code == CODE_WHEEL_DOWN)
        wheel_q = press ? WHEEL_DOWN : WHEEL_NONE;
      else if (code <= CODE_EXTRA2)
        btn_now[code] = press;
    end

    // squared distance against squared threshold
    ax       = (step_x < 0) ? -int'(step_x) : int'(step_x);
    ay       = (step_y < 0) ? -int'(step_y) : int'(step_y);
    dist_sq  = longint'(ax) * ax + longint'(ay) * ay;
    floor_sq = longint'(min_move) * min_move;
    moved    = (dist_sq >= floor_sq);

    if (moved || wheel_q != WHEEL_NONE) begin
      act_q     = 1'b1;
      act_stamp = now;
    end

    // per-button click, double click and hold
    for (int i = 0; i < 5; i++) begin
      if (btn_now[i]) begin
        nothing   = 1'b0;
        act_q     = 1'b1;
        act_stamp = now;
        elapsed   = now - release_stamp[i];
        if (btn_prev[i])
          holds[i] = 1'b1;
        else if (elapsed < {16'd0, dclick_window})
          dclicks[i] = 1'b1;
      end else if (btn_prev[i]) begin
        nothing          = 1'b0;
        clicks[i]        = 1'b1;
        release_stamp[i] = now;
      end
    end
    btn_prev = btn_now;

    // inactivity timeout after the update
    elapsed = now - act_stamp;
    if (act_q && elapsed > {12'd0, idle_timeout}) begin
      act_q     = 1'b0;
      act_stamp = now;
      timeouts_seen++;
    end

    r.fill         = '0;
    r.nothing_down = nothing;
    r.active_out   = act_q & ptr_enable;
    r.moved        = moved;
    r.hold_mask    = holds;
    r.dclick_mask  = dclicks;
    r.click_mask   = clicks;
    r.buttons_down = btn_now;
    r.wheel_dir    = wheel_q;
    r.delta_y      = step_y;
    r.delta_x      = step_x;
    r.cur_y        = trk_y;
    r.cur_x        = trk_x;
  endtask

  // field-by-field comparison of one result beat
  function automatic void check_result(click_result_t want, click_result_t got);
    logic bad;
    bad = (got.cur_x !== want.cur_x) || (got.cur_y !== want.cur_y) ||
          (got.delta_x !== want.delta_x) || (got.delta_y !== want.delta_y) ||
          (got.wheel_dir !== want.wheel_dir) ||
          (got.buttons_down !== want.buttons_down) ||
          (got.click_mask !== want.click_mask) ||
          (got.dclick_mask !== want.dclick_mask) ||
          (got.hold_mask !== want.hold_mask) || (got.moved !== want.moved) ||
          (got.active_out !== want.active_out) ||
          (got.nothing_down !== want.nothing_down) || (got.fill !== want.fill);
    if (bad) begin
      if (mismatch_count < REPORT_LIMIT) begin
        $display("mismatch at result %0d (t=%0t)", results_seen, $realtime);
        $display("  exp pos=%0d,%0d d=%0d,%0d wh=%0d btn=%b clk=%b dbl=%b hold=%b mv=%b act=%b none=%b",
                 want.cur_x, want.cur_y, want.delta_x, want.delta_y, want.wheel_dir,
                 want.buttons_down, want.click_mask, want.dclick_mask, want.hold_mask,
                 want.moved, want.active_out, want.nothing_down);
        $display("  got pos=%0d,%0d d=%0d,%0d wh=%0d btn=%b clk=%b dbl=%b hold=%b mv=%b act=%b none=%b fill=%b",
                 got.cur_x, got.cur_y, got.delta_x, got.delta_y, got.wheel_dir,
                 got.buttons_down, got.click_mask, got.dclick_mask, got.hold_mask,
                 got.moved, got.active_out, got.nothing_down, got.fill);
      end
      mismatch_count++;
    end
  endfunction

  // beat monitor: predict on accepted events, check accepted results
  always @(posedge clk) begin
    click_result_t want, got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (expected_results.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("result beat with no event pending (t=%0t)", $realtime);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_result(want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_pointer(s_tdata[31:0], s_tdata[43:32], s_tdata[55:44],
                        s_tuser[1:0], s_tuser[4:2], want);
        if (want.click_mask != 0) clicks_seen++;
        if (want.dclick_mask != 0) dclicks_seen++;
        if (want.hold_mask != 0) holds_seen++;
        expected_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        cfg_writes++;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("FAIL pointer_event_click_detector");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result receiver with random stalls
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && !rst));
    end
  end

  // one event beat with a random gap in front
  task automatic send_event(input logic [31:0] t, input logic [11:0] x, input logic [11:0] y,
                            input logic [1:0] kind, input logic [2:0] code);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x, t};
    s_tuser  <= {code, kind};
    do @(posedge clk); while (!s_tready);
    events_sent++;
  endtask

  // stop sending and wait for every pending result
  task automatic drain_events();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    drain_events();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // event usually at a slightly later time and a nearby position, sometimes a jump
  task automatic step_event(input logic [1:0] kind, input logic [2:0] code, input int dt_max);
    int dt;
    dt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, dt_max);
    clock_now = clock_now + dt;
    if ($urandom_range(0, 15) == 0) begin
      walk_x = $urandom_range(0, 4095);
      walk_y = $urandom_range(0, 4095);
    end else begin
      walk_x = walk_x + $urandom_range(0, 24) - 12;
      walk_y = walk_y + $urandom_range(0, 24) - 12;
      walk_x = (walk_x < 0) ? 0 : (walk_x > 4095) ? 4095 : walk_x;
      walk_y = (walk_y < 0) ? 0 : (walk_y > 4095) ? 4095 : walk_y;
    end
    send_event(clock_now, 12'(walk_x), 12'(walk_y), kind, code);
  endtask

  // register value for a phase: all zero, all top, or a mix
  function automatic int unsigned pick_setting(int phase, int unsigned top, int unsigned typical);
    int sel;
    sel = $urandom_range(0, 5);
    if (phase == 1) return 0;
    if (phase == 2) return top;
    if (sel == 0) return 0;
    if (sel == 1) return top;
    return $urandom_range(0, typical);
  endfunction

  // first event takes its position, later ones give a delta
  task automatic test_first_event();
    send_event(32'd100, 12'd10, 12'd20, KIND_MOTION, CODE_LEFT);
    send_event(32'd110, 12'd4095, 12'd4095, KIND_MOTION, CODE_LEFT);
    send_event(32'd120, 12'd0, 12'd0, KIND_MOTION, CODE_LEFT);
  endtask

  // clamping at zero and full-scale limits
  task automatic test_clamp_extremes();
    write_reg(CFG_MAX_X, 0);
    write_reg(CFG_MAX_Y, 4095);
    send_event(32'd200, 12'd4095, 12'd4095, KIND_MOTION, CODE_LEFT);
    send_event(32'd210, 12'd0, 12'd4095, KIND_MOTION, CODE_LEFT);
    write_reg(CFG_MAX_X, 4095);
    write_reg(CFG_MAX_Y, 0);
    send_event(32'd220, 12'd4095, 12'd0, KIND_MOTION, CODE_LEFT);
    send_event(32'd230, 12'd4095, 12'd4095, KIND_MOTION, CODE_LEFT);
  endtask

  // press, hold, click and double click, plus ignored codes
  task automatic test_button_codes();
    send_event(32'd300, 12'd100, 12'd100, KIND_PRESS, CODE_LEFT);
    send_event(32'd310, 12'd100, 12'd100, KIND_PRESS, CODE_EXTRA2);
    send_event(32'd320, 12'd100, 12'd100, KIND_PRESS, CODE_NONE);
    send_event(32'd330, 12'd101, 12'd100, KIND_OTHER, CODE_RIGHT);
    send_event(32'd340, 12'd101, 12'd100, KIND_RELEASE, CODE_LEFT);
    send_event(32'd350, 12'd101, 12'd100, KIND_PRESS, CODE_LEFT);
    send_event(32'd360, 12'd101, 12'd100, KIND_RELEASE, CODE_LEFT);
    send_event(32'd3000, 12'd101, 12'd100, KIND_RELEASE, CODE_EXTRA2);
    send_event(32'd3600, 12'd101, 12'd100, KIND_PRESS, CODE_EXTRA2);
    send_event(32'd3610, 12'd101, 12'd100, KIND_RELEASE, CODE_EXTRA2);
  endtask

  // wheel press sets a direction, release clears it
  task automatic test_wheel();
    send_event(32'd3700, 12'd101, 12'd100, KIND_PRESS, CODE_WHEEL_UP);
    send_event(32'd3710, 12'd101, 12'd100, KIND_RELEASE, CODE_WHEEL_UP);
    send_event(32'd3720, 12'd101, 12'd100, KIND_PRESS, CODE_WHEEL_DOWN);
    send_event(32'd3730, 12'd101, 12'd100, KIND_RELEASE, CODE_WHEEL_DOWN);
  endtask

  // zero timeout, disabled output, wide window across a time wrap
  task automatic test_activity_and_wrap();
    write_reg(CFG_ACTIVE_TIMEOUT, 0);
    write_reg(CFG_POINTER_EN, 0);
    write_reg(CFG_MIN_MOVEMENT, 4095);
    send_event(32'd5000, 12'd101, 12'd100, KIND_MOTION, CODE_LEFT);
    send_event(32'd5001, 12'd101, 12'd100, KIND_MOTION, CODE_LEFT);
    write_reg(CFG_POINTER_EN, 1);
    write_reg(CFG_ACTIVE_TIMEOUT, 1048575);
    write_reg(CFG_DCLICK_WINDOW, 65535);
    send_event(32'hFFFF_FFF0, 12'd101, 12'd100, KIND_PRESS, CODE_RIGHT);
    send_event(32'hFFFF_FFF8, 12'd101, 12'd100, KIND_RELEASE, CODE_RIGHT);
    send_event(32'h0000_0010, 12'd101, 12'd100, KIND_PRESS, CODE_RIGHT);
    send_event(32'h0000_0020, 12'd101, 12'd100, KIND_RELEASE, CODE_RIGHT);
  endtask

  // phases of gestures with random content and some raw noise
  task automatic test_random_traffic();
    int         n;
    int         extra;
    logic [2:0] code;
    for (int phase = 0; phase < PHASES; phase++) begin
      write_reg(CFG_MAX_X, pick_setting(phase, 4095, 4095));
      write_reg(CFG_MAX_Y, pick_setting(phase, 4095, 4095));
      write_reg(CFG_DCLICK_WINDOW, pick_setting(phase, 65535, 1000));
      write_reg(CFG_MIN_MOVEMENT, pick_setting(phase, 4095, 30));
      write_reg(CFG_ACTIVE_TIMEOUT, pick_setting(phase, 1048575, 4000));
      write_reg(CFG_POINTER_EN, (phase == 1) ? 0 : (phase == 2) ? 1 : $urandom_range(0, 1));
      n = 0;
      while (n < PHASE_EVENTS) begin
        if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
        if ($urandom_range(0, 9) < 2) begin
          // raw noise over every field bit
          send_event($urandom, 12'($urandom), 12'($urandom), 2'($urandom), 3'($urandom));
          n++;
        end else begin
          // press, a few moves, release, sometimes a quick second click
          code = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 6))
                                             : 3'($urandom_range(0, 4));
          step_event(KIND_PRESS, code, 400);
          extra = $urandom_range(0, 3);
          repeat (extra) step_event(KIND_MOTION, 3'($urandom), 400);
          step_event(KIND_RELEASE, code, 400);
          n += extra + 2;
          if ($urandom_range(0, 1) == 1) begin
            step_event(KIND_PRESS, code, 200);
            step_event(KIND_RELEASE, code, 200);
            n += 2;
          end
        end
      end
    end
  endtask

  // test sequence
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    clock_now = 32'd10000;
    walk_x    = 300;
    walk_y    = 300;

    lim_x         = 12'd720;
    lim_y         = 12'd576;
    dclick_window = 16'd500;
    min_move      = 12'd5;
    idle_timeout  = 20'd5000;
    ptr_enable    = 1'b1;
    trk_x         = '0;
    trk_y         = '0;
    trk_valid     = 1'b0;
    step_x        = '0;
    step_y        = '0;
    wheel_q       = WHEEL_NONE;
    btn_now       = '0;
    btn_prev      = '0;
    for (int i = 0; i < 5; i++) release_stamp[i] = '0;
    act_q         = 1'b0;
    act_stamp     = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_event();
    test_clamp_extremes();
    test_button_codes();
    test_wheel();
    test_activity_and_wrap();
    test_random_traffic();

    drain_events();
    repeat (END_PAUSE) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      mismatch_count += expected_results.size();
    end

    $display("ran %0d events and %0d results over %0d register writes, %0d mismatches",
             events_sent, results_seen, cfg_writes, mismatch_count);
    $display("events with clicks %0d, double clicks %0d, holds %0d, timeouts %0d",
             clicks_seen, dclicks_seen, holds_seen, timeouts_seen);
    if (mismatch_count == 0) begin
      $display("PASS pointer_event_click_detector");
    end else begin
      $display("FAIL pointer_event_click_detector");
    end
    $finish;
  end

endmodule
